>>> design/ard_pkg.sv
// Shared types, codes and constants of the audio ring dispenser.
package ard_pkg;

  localparam int unsigned RingDepth = 2048;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned SizeW     = 12;
  localparam int unsigned KindW     = 3;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned ModeW     = 3;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [SizeW-1:0] RingSizeRst = 12'd1280;
  localparam logic [SizeW-1:0] StartThrRst = 12'd1280;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRingSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgStartThr = 1'b1;

  typedef enum logic [KindW-1:0] {
    KIND_START   = 3'd0,
    KIND_STOP    = 3'd1,
    KIND_LINK_WR = 3'd2,
    KIND_CORE_RD = 3'd3,
    KIND_QUERY   = 3'd4
  } kind_e;

  typedef enum logic [ModeW-1:0] {
    MODE_OFF       = 3'd0,
    MODE_HELD      = 3'd1,
    MODE_CHARGING  = 3'd2,
    MODE_OPERATING = 3'd3,
    MODE_OVERFULL  = 3'd4
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 2'd0,
    ST_WRONG_MODE = 2'd1,
    ST_NO_SPACE   = 2'd2,
    ST_NO_DATA    = 2'd3
  } status_e;

  typedef struct packed {
    logic [KindW-1:0]          kind;
    logic signed [SampleW-1:0] link_sample;
    logic signed [SampleW-1:0] core_sample;
    logic [SizeW-1:0]          query_len;
  } item_t;

  typedef struct packed {
    logic [StatusW-1:0]        status;
    logic signed [SampleW-1:0] sample_out;
    logic                      space_ready;
    logic [SizeW-1:0]          fill_level;
    logic [ModeW-1:0]          mode;
  } result_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr;
    logic accept;
    logic rem_step;
    logic exec;
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic rem_need;
    logic rem_last;
  } dp_stat_t;

endpackage

>>> design/ard_datapath.sv
// Datapath: configuration, fill state, position remainder unit and both ring memories.
module ard_datapath #(
  parameter int unsigned RING_DEPTH = ard_pkg::RingDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ard_pkg::ctl_t                 ctl_i,
  output ard_pkg::dp_stat_t             stat_o,
  input  logic                          cfg_we_i,
  input  logic [ard_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ard_pkg::SizeW-1:0]     cfg_wdata_i,
  input  ard_pkg::item_t                item_i,
  output ard_pkg::result_t              result_o
);

  localparam int unsigned AW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned SW   = ard_pkg::SizeW;
  localparam int unsigned CW   = SW + 1;
  localparam int unsigned DW   = ard_pkg::SampleW;
  localparam int unsigned CntW = $clog2(AW + 1);
  localparam logic [AW-1:0] LastAddr = AW'(RING_DEPTH - 1);

  logic [SW-1:0]       ring_size_q;
  logic [SW-1:0]       start_thr_q;
  ard_pkg::mode_e      mode_q, mode_d;
  logic [SW-1:0]       fill_q, fill_d;
  logic [AW-1:0]       read_pos_q, read_pos_d;
  logic [AW-1:0]       clr_idx_q;

  ard_pkg::item_t      item_q;
  logic [SW-1:0]       rp_q;
  logic [SW-1:0]       rem_q;
  logic [AW-1:0]       dvd_q;
  logic [CntW-1:0]     cnt_q;
  logic [ard_pkg::StatusW-1:0] status_q;
  logic                ready_q;
  logic                sel_from_q, sel_to_q;
  logic [DW-1:0]       rd_from_q, rd_to_q;

  logic [DW-1:0]       mem_from [RING_DEPTH];
  logic [DW-1:0]       mem_to   [RING_DEPTH];

  logic [SW-1:0]       size;
  logic [CW-1:0]       size_c;
  logic [CW-1:0]       rem_shift, rem_nxt;
  logic [CW-1:0]       wsum, wp, rp_inc, rp_next, qsum;
  logic [SW-1:0]       fill_inc, fill_dec;
  logic [AW-1:0]       addr;
  ard_pkg::status_e    status_d;
  logic                ready_d, wr_from, wr_to, sel_from_d, sel_to_d;

  // Ring size in use: zero taken as one, clamp to the memory depth.
  always_comb begin
    if (ring_size_q == '0) begin
      size = SW'(1);
    end else if (32'(ring_size_q) > 32'(RING_DEPTH)) begin
      size = SW'(RING_DEPTH);
    end else begin
      size = ring_size_q;
    end
  end
  assign size_c = CW'(size);

  // One restoring step of read_pos mod size.
  assign rem_shift = {rem_q, dvd_q[AW-1]};
  assign rem_nxt   = (rem_shift >= size_c) ? rem_shift - size_c : rem_shift;

  assign stat_o.clr_last = (clr_idx_q == LastAddr);
  assign stat_o.rem_need = (32'(read_pos_q) >= 32'(size));
  assign stat_o.rem_last = (cnt_q == CntW'(1));

  assign wsum     = CW'(rp_q) + CW'(fill_q);
  assign wp       = (wsum >= size_c) ? wsum - size_c : wsum;
  assign rp_inc   = CW'(rp_q) + CW'(1);
  assign rp_next  = (rp_inc == size_c) ? '0 : rp_inc;
  assign qsum     = CW'(fill_q) + CW'(item_q.query_len);
  assign fill_inc = fill_q + SW'(1);
  assign fill_dec = fill_q - SW'(1);

  always_comb begin
    mode_d     = mode_q;
    fill_d     = fill_q;
    read_pos_d = read_pos_q;
    status_d   = ard_pkg::ST_OK;
    ready_d    = 1'b0;
    wr_from    = 1'b0;
    wr_to      = 1'b0;
    sel_from_d = 1'b0;
    sel_to_d   = 1'b0;
    addr       = AW'(rp_q);
    case (item_q.kind)
      ard_pkg::KIND_START: begin
        if (mode_q == ard_pkg::MODE_OFF) begin
          mode_d     = ard_pkg::MODE_HELD;
          fill_d     = '0;
          read_pos_d = '0;
        end else begin
          status_d = ard_pkg::ST_WRONG_MODE;
        end
      end
      ard_pkg::KIND_STOP: begin
        if (mode_q != ard_pkg::MODE_OFF) begin
          mode_d = ard_pkg::MODE_OFF;
        end else begin
          status_d = ard_pkg::ST_WRONG_MODE;
        end
      end
      ard_pkg::KIND_LINK_WR: begin
        if (mode_q != ard_pkg::MODE_CHARGING && mode_q != ard_pkg::MODE_OPERATING) begin
          status_d = ard_pkg::ST_WRONG_MODE;
        end else if (fill_q < size) begin
          addr     = AW'(wp);
          wr_from  = 1'b1;
          sel_to_d = 1'b1;
          fill_d   = fill_inc;
          if (mode_q == ard_pkg::MODE_CHARGING && fill_inc >= start_thr_q) begin
            mode_d = ard_pkg::MODE_OPERATING;
          end
        end else begin
          mode_d   = ard_pkg::MODE_OVERFULL;
          status_d = ard_pkg::ST_NO_SPACE;
        end
      end
      ard_pkg::KIND_CORE_RD: begin
        if (mode_q != ard_pkg::MODE_OPERATING && mode_q != ard_pkg::MODE_OVERFULL) begin
          if (mode_q == ard_pkg::MODE_HELD) begin
            mode_d = ard_pkg::MODE_CHARGING;
          end
          status_d = ard_pkg::ST_WRONG_MODE;
        end else if (fill_q != '0) begin
          wr_to      = 1'b1;
          sel_from_d = 1'b1;
          fill_d     = fill_dec;
          read_pos_d = AW'(rp_next);
          if (mode_q == ard_pkg::MODE_OVERFULL && fill_dec < start_thr_q) begin
            mode_d = ard_pkg::MODE_OPERATING;
          end
        end else begin
          mode_d   = ard_pkg::MODE_CHARGING;
          status_d = ard_pkg::ST_NO_DATA;
        end
      end
      ard_pkg::KIND_QUERY: begin
        if ((mode_q == ard_pkg::MODE_CHARGING || mode_q == ard_pkg::MODE_OPERATING) &&
            qsum <= size_c) begin
          ready_d = 1'b1;
        end
      end
      default: begin
        status_d = ard_pkg::ST_WRONG_MODE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q <= ard_pkg::RingSizeRst;
      start_thr_q <= ard_pkg::StartThrRst;
      mode_q      <= ard_pkg::MODE_OFF;
      fill_q      <= '0;
      read_pos_q  <= '0;
      clr_idx_q   <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == ard_pkg::CfgRingSize) begin
          ring_size_q <= cfg_wdata_i;
        end
        if (cfg_idx_i == ard_pkg::CfgStartThr) begin
          start_thr_q <= cfg_wdata_i;
        end
      end
      if (ctl_i.clr) begin
        clr_idx_q <= clr_idx_q + AW'(1);
      end
      if (ctl_i.accept) begin
        cnt_q <= CntW'(AW);
      end else if (ctl_i.rem_step) begin
        cnt_q <= cnt_q - CntW'(1);
      end
      if (ctl_i.exec) begin
        mode_q     <= mode_d;
        fill_q     <= fill_d;
        read_pos_q <= read_pos_d;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      item_q <= item_i;
      rp_q   <= SW'(read_pos_q);
      rem_q  <= '0;
      dvd_q  <= read_pos_q;
    end else if (ctl_i.rem_step) begin
      rem_q <= SW'(rem_nxt);
      dvd_q <= dvd_q << 1;
      rp_q  <= SW'(rem_nxt);
    end
    if (ctl_i.exec) begin
      status_q   <= status_d;
      ready_q    <= ready_d;
      sel_from_q <= sel_from_d;
      sel_to_q   <= sel_to_d;
    end
  end

  // Frames from the link
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      mem_from[clr_idx_q] <= '0;
    end else if (ctl_i.exec) begin
      if (wr_from) begin
        mem_from[addr] <= item_q.link_sample;
      end
      rd_from_q <= mem_from[addr];
    end
  end

  // Frames to the link
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      mem_to[clr_idx_q] <= '0;
    end else if (ctl_i.exec) begin
      if (wr_to) begin
        mem_to[addr] <= item_q.core_sample;
      end
      rd_to_q <= mem_to[addr];
    end
  end

  assign result_o.status      = status_q;
  assign result_o.sample_out  = sel_from_q ? rd_from_q : (sel_to_q ? rd_to_q : '0);
  assign result_o.space_ready = ready_q;
  assign result_o.fill_level  = fill_q;
  assign result_o.mode        = mode_q;

endmodule

>>> design/ard_ctrl.sv
// Controller: sequences clearing, position remainder, execution and result strobe.
module ard_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  input  ard_pkg::dp_stat_t stat_i,
  output ard_pkg::ctl_t     ctl_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REM,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, done_q;
  logic   accept;

  assign accept = start_i & ~busy_q;

  always_comb begin
    state_d      = state_q;
    ctl_o        = '0;
    ctl_o.accept = accept;
    case (state_q)
      S_CLEAR: begin
        ctl_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE, S_RESP: begin
        if (accept) begin
          state_d = stat_i.rem_need ? S_REM : S_EXEC;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_REM: begin
        ctl_o.rem_step = 1'b1;
        if (stat_i.rem_last) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl_o.exec = 1'b1;
        state_d    = S_RESP;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE) && (state_d != S_RESP);
      done_q  <= (state_d == S_RESP);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

>>> design/audio_ring_dispenser.sv
// Top level of the audio ring dispenser: controller and datapath.
//
// Paired audio ring buffer run by a five-mode fill machine (off, held, charging,
// operating, overfull). Raise start for one cycle while busy is low to hand over
// an item; the result appears on result_o, marked by done_o for exactly one
// cycle, after the remainder steps (if any) and the execute state, and the
// receiver cannot hold it off, so take it in that cycle. A new item may be
// handed over in the same cycle as the strobe; during the remainder and execute
// states busy is high and no new item is taken.
// When a shortened ring size has left the read position beyond the ring, the
// position is first reduced by a bit-serial remainder unit, one bit per cycle,
// across every bit of the read position, before that item executes. After reset
// both ring memories are cleared one entry per cycle; busy stays high until the
// last entry is cleared and no item is taken, though configuration writes are.
// Write the ring size and the fill threshold only while the block is idle.
module audio_ring_dispenser #(
  parameter int unsigned RING_DEPTH = ard_pkg::RingDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  ard_pkg::item_t              item_i,
  output logic                        done_o,
  output ard_pkg::result_t            result_o,
  input  logic                        cfg_we_i,
  input  logic [ard_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ard_pkg::SizeW-1:0]   cfg_wdata_i
);

  ard_pkg::ctl_t     ctl;
  ard_pkg::dp_stat_t dp_stat;

  // Sequence each item: remainder if needed, execute, strobe.
  ard_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .stat_i  (dp_stat),
    .ctl_o   (ctl)
  );

  // Hold fill state, configuration and both rings.
  ard_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .stat_o      (dp_stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .result_o    (result_o)
  );

endmodule

>>> design/ard_checker.sv
// Port-level checks of the audio ring dispenser and their binding.
module ard_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input ard_pkg::result_t result_o
);

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after an item was taken");

  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_no_space_overfull : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status == ard_pkg::ST_NO_SPACE |->
      result_o.mode == ard_pkg::MODE_OVERFULL)
    else $error("no-space result without overfull mode");

  a_no_data_charging : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status == ard_pkg::ST_NO_DATA |->
      result_o.mode == ard_pkg::MODE_CHARGING && result_o.fill_level == '0)
    else $error("underflow result without empty charging ring");

  a_ready_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.space_ready |->
      result_o.status == ard_pkg::ST_OK &&
      (result_o.mode == ard_pkg::MODE_CHARGING || result_o.mode == ard_pkg::MODE_OPERATING))
    else $error("space ready outside charging or operating");

endmodule

bind audio_ring_dispenser ard_checker u_ard_checker (.*);
